// ===== hw/rtl/bed_pkg.sv =====
// shared types and constants of the button event detector
`timescale 1ns / 1ps
`default_nettype none
package bed_pkg;

    // debounce phase of one key
    typedef enum logic [2:0] {
        PH_NONE         = 3'd0,
        PH_PRESS_DEB    = 3'd1,
        PH_PRESS        = 3'd2,
        PH_PRESSING_DEB = 3'd3,
        PH_PRESSING     = 3'd4,
        PH_RELEASE      = 3'd5
    } phase_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG         = 3'd1,
        REG_MULTI        = 3'd2,
        REG_REPEAT_FIRST = 3'd3,
        REG_REPEAT_PER   = 3'd4,
        REG_FEATURES     = 3'd5
    } reg_index_t;

    localparam int CFG_W  = 16;
    localparam int FEAT_W = 5;

    // feature enable bit positions
    localparam int FEAT_LONG_PRESS    = 0;
    localparam int FEAT_LONG_RELEASE  = 1;
    localparam int FEAT_MULTI_PRESS   = 2;
    localparam int FEAT_MULTI_RELEASE = 3;
    localparam int FEAT_REPEAT        = 4;

    // register values after reset
    localparam logic [CFG_W-1:0]  DEBOUNCE_RST     = 16'd20;
    localparam logic [CFG_W-1:0]  LONG_RST         = 16'd1000;
    localparam logic [CFG_W-1:0]  MULTI_RST        = 16'd300;
    localparam logic [CFG_W-1:0]  REPEAT_FIRST_RST = 16'd1000;
    localparam logic [CFG_W-1:0]  REPEAT_PER_RST   = 16'd200;
    localparam logic [FEAT_W-1:0] FEATURES_RST     = 5'd0;

    localparam logic [7:0] CLICK_MAX = 8'hFF;
    localparam logic [7:0] CLICK_MULTI_MIN = 8'd2;
    localparam logic [4:0] TOTAL_MAX = 5'd31;

endpackage
`default_nettype wire

// ===== hw/rtl/bed_state_ram.sv =====
// per-key state memory with valid bits and write-to-read bypass
`timescale 1ns / 1ps
`default_nettype none
module bed_state_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // an entry never written reads as all zero
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else if (valid_reg[rd_addr]) begin
                rd_data_reg <= mem_reg[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/button_event_detector.sv =====
// top level of the button event detector
// a request is held in the request register, then its result in the result register
// throughput: one request per cycle unless the result side stalls, set by the single
// state read-modify-write; read at acceptance, update and write-back when it completes
// reset: tick, key count and registers to defaults, all keys idle at once
// (valid bits clear the key store, no clearing pass)
`timescale 1ns / 1ps
`default_nettype none
module button_event_detector #(
    parameter int KEYS      = 16,
    parameter int TICK_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // sample requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_key_index,
    input  wire logic        s_key_level,
    input  wire logic        s_tick_advance,
    // event results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_key,
    output logic             m_press_event,
    output logic             m_release_event,
    output logic             m_held_event,
    output logic             m_long_press_event,
    output logic             m_long_release_event,
    output logic             m_multi_press_event,
    output logic             m_multi_release_event,
    output logic [7:0]       m_click_count,
    output logic             m_repeat_event,
    output logic [4:0]       m_keys_down
);

    localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;

    // per-key state; long press and long release deadlines are always
    // written together with the same value, so one field holds both
    typedef struct packed {
        logic [TICK_BITS-1:0] repeat_dl;
        logic [TICK_BITS-1:0] release_click_dl;
        logic [7:0]           release_clicks;
        logic [TICK_BITS-1:0] press_click_dl;
        logic [7:0]           press_clicks;
        logic                 long_fired;
        logic [TICK_BITS-1:0] long_dl;
        logic [TICK_BITS-1:0] debounce_dl;
        logic                 armed;
        bed_pkg::phase_t      phase;
        logic                 settled;
    } key_rec_t;

    localparam int STATE_W = $bits(key_rec_t);

    // deadline reached when (now - deadline) as a signed value is not negative
    function automatic logic reached(input logic [TICK_BITS-1:0] now,
                                     input logic [TICK_BITS-1:0] dl);
        logic [TICK_BITS-1:0] diff;
        diff = now - dl;
        return !diff[TICK_BITS-1];
    endfunction

    function automatic logic [TICK_BITS-1:0] later(input logic [TICK_BITS-1:0] now,
                                                   input logic [15:0] span);
        return now + TICK_BITS'(span);
    endfunction

    // configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] long_reg;
    logic [15:0] multi_reg;
    logic [15:0] rep_first_reg;
    logic [15:0] rep_period_reg;
    logic [4:0]  features_reg;

    // request stage
    logic                 in_valid_reg;
    logic [3:0]           key_reg;
    logic                 level_reg;
    logic [TICK_BITS-1:0] in_tick_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] tick_next;

    // shared count of pressed keys
    logic [4:0] total_reg;
    logic [4:0] total_next;

    // result stage
    logic       out_valid_reg;
    logic [3:0] ev_key_reg;
    logic       ev_press_reg;
    logic       ev_release_reg;
    logic       ev_held_reg;
    logic       ev_long_press_reg;
    logic       ev_long_release_reg;
    logic       ev_multi_press_reg;
    logic       ev_multi_release_reg;
    logic [7:0] ev_click_reg;
    logic       ev_repeat_reg;
    logic [4:0] ev_down_reg;

    // handshake
    logic s_fire;
    logic work_fire;

    // state store
    logic [STATE_W-1:0] rd_data;
    key_rec_t           st;
    key_rec_t           nx;
    logic               in_range;
    logic               wr_en;

    // combinational event flags of the request in work
    logic       press_ev;
    logic       release_ev;
    logic       held_ev;
    logic       long_press_ev;
    logic       long_release_ev;
    logic       multi_press_ev;
    logic       multi_release_ev;
    logic [7:0] click_ev;
    logic       repeat_ev;

    // a fresh click deadline (now + interval) counts as reached only for
    // intervals whose negation has a clear sign bit; depends on config alone
    logic [TICK_BITS-1:0] neg_multi;
    logic                 fresh_click_reached;

    assign work_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || work_fire;
    assign s_fire    = s_valid && s_ready;
    assign tick_next = tick_reg + TICK_BITS'(s_tick_advance);

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= bed_pkg::DEBOUNCE_RST;
            long_reg       <= bed_pkg::LONG_RST;
            multi_reg      <= bed_pkg::MULTI_RST;
            rep_first_reg  <= bed_pkg::REPEAT_FIRST_RST;
            rep_period_reg <= bed_pkg::REPEAT_PER_RST;
            features_reg   <= bed_pkg::FEATURES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bed_pkg::REG_DEBOUNCE:     debounce_reg   <= cfg_data;
                bed_pkg::REG_LONG:         long_reg       <= cfg_data;
                bed_pkg::REG_MULTI:        multi_reg      <= cfg_data;
                bed_pkg::REG_REPEAT_FIRST: rep_first_reg  <= cfg_data;
                bed_pkg::REG_REPEAT_PER:   rep_period_reg <= cfg_data;
                bed_pkg::REG_FEATURES:     features_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // request register; the tick advances by the advance flag as each request is taken,
    // and the request carries the tick it must see
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            tick_reg     <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
                tick_reg     <= tick_next;
            end else if (work_fire) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            key_reg     <= s_key_index;
            level_reg   <= s_key_level;
            in_tick_reg <= tick_next;
        end
    end

    // key state store: read at acceptance, written back when the request completes
    bed_state_ram #(
        .WIDTH (STATE_W),
        .DEPTH (KEYS),
        .AW    (KEY_AW)
    ) u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (KEY_AW'(s_key_index)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (KEY_AW'(key_reg)),
        .wr_data (nx)
    );

    assign st       = key_rec_t'(rd_data);
    assign in_range = (32'(key_reg) < KEYS);
    assign wr_en    = work_fire && in_range;

    assign neg_multi           = '0 - TICK_BITS'(multi_reg);
    assign fresh_click_reached = !neg_multi[TICK_BITS-1];

    // per-key update
    always_comb begin
        logic            go;
        logic            waiting;
        logic            pressing;
        bed_pkg::phase_t ph;
        logic [7:0]      clicks;

        nx               = st;
        press_ev         = 1'b0;
        release_ev       = 1'b0;
        held_ev          = 1'b0;
        long_press_ev    = 1'b0;
        long_release_ev  = 1'b0;
        multi_press_ev   = 1'b0;
        multi_release_ev = 1'b0;
        click_ev         = '0;
        repeat_ev        = 1'b0;
        total_next       = total_reg;
        clicks           = '0;

        go = (debounce_reg == '0) || (st.armed && reached(in_tick_reg, st.debounce_dl));

        // level against settled level
        unique case ({level_reg, st.settled})
            2'b00: begin
                nx.armed = 1'b0;
                nx.phase = bed_pkg::PH_NONE;
            end
            2'b01: begin
                if (go) begin
                    nx.phase   = bed_pkg::PH_RELEASE;
                    release_ev = 1'b1;
                end else if (!st.armed) begin
                    nx.phase       = bed_pkg::PH_PRESSING_DEB;
                    nx.debounce_dl = later(in_tick_reg, debounce_reg);
                    nx.armed       = 1'b1;
                end
            end
            2'b10: begin
                if (go) begin
                    nx.phase = bed_pkg::PH_PRESS;
                    press_ev = 1'b1;
                end else if (!st.armed) begin
                    nx.phase       = bed_pkg::PH_PRESS_DEB;
                    nx.debounce_dl = later(in_tick_reg, debounce_reg);
                    nx.armed       = 1'b1;
                end
            end
            2'b11: begin
                nx.armed = 1'b0;
                nx.phase = bed_pkg::PH_PRESSING;
                held_ev  = 1'b1;
            end
        endcase

        // a waiting key keeps its last phase, and what follows acts on it again
        ph       = nx.phase;
        waiting  = (ph == bed_pkg::PH_PRESS_DEB) || (ph == bed_pkg::PH_PRESSING_DEB);
        pressing = (ph == bed_pkg::PH_PRESSING) || (ph == bed_pkg::PH_PRESSING_DEB);

        if (!waiting) begin
            nx.settled = level_reg;
        end

        if (ph == bed_pkg::PH_PRESS) begin
            if (total_reg != bed_pkg::TOTAL_MAX) begin
                total_next = total_reg + 5'd1;
            end
        end else if (ph == bed_pkg::PH_RELEASE) begin
            if (total_reg != '0) begin
                total_next = total_reg - 5'd1;
            end
        end

        // long press and long release
        if (ph == bed_pkg::PH_PRESS) begin
            nx.long_dl    = later(in_tick_reg, long_reg);
            nx.long_fired = 1'b0;
        end else if (pressing) begin
            if (features_reg[bed_pkg::FEAT_LONG_PRESS] &&
                reached(in_tick_reg, st.long_dl) && !st.long_fired) begin
                nx.long_fired = 1'b1;
                long_press_ev = 1'b1;
            end
        end else if (ph == bed_pkg::PH_RELEASE) begin
            if (features_reg[bed_pkg::FEAT_LONG_RELEASE] &&
                reached(in_tick_reg, st.long_dl)) begin
                long_release_ev = 1'b1;
            end
        end

        // multi press
        if (features_reg[bed_pkg::FEAT_MULTI_PRESS] && (ph == bed_pkg::PH_PRESS)) begin
            clicks = (st.press_clicks != bed_pkg::CLICK_MAX) ?
                     st.press_clicks + 8'd1 : st.press_clicks;
            if (clicks >= bed_pkg::CLICK_MULTI_MIN) begin
                multi_press_ev = 1'b1;
                click_ev       = clicks;
            end
            nx.press_click_dl = later(in_tick_reg, multi_reg);
            nx.press_clicks   = fresh_click_reached ? '0 : clicks;
        end else if ((st.press_clicks != '0) && reached(in_tick_reg, st.press_click_dl)) begin
            nx.press_clicks = '0;
        end

        // multi release
        if (features_reg[bed_pkg::FEAT_MULTI_RELEASE] && (ph == bed_pkg::PH_RELEASE)) begin
            clicks = (st.release_clicks != bed_pkg::CLICK_MAX) ?
                     st.release_clicks + 8'd1 : st.release_clicks;
            if (clicks >= bed_pkg::CLICK_MULTI_MIN) begin
                multi_release_ev = 1'b1;
                click_ev         = clicks;
            end
            nx.release_click_dl = later(in_tick_reg, multi_reg);
            nx.release_clicks   = fresh_click_reached ? '0 : clicks;
        end else if ((st.release_clicks != '0) &&
                     reached(in_tick_reg, st.release_click_dl)) begin
            nx.release_clicks = '0;
        end

        // auto-repeat
        if (ph == bed_pkg::PH_PRESS) begin
            nx.repeat_dl = later(in_tick_reg, rep_first_reg);
        end else if (pressing) begin
            if (features_reg[bed_pkg::FEAT_REPEAT] && reached(in_tick_reg, st.repeat_dl)) begin
                repeat_ev    = 1'b1;
                nx.repeat_dl = later(in_tick_reg, rep_period_reg);
            end
        end

        // a key beyond the store changes nothing and reports nothing
        if (!in_range) begin
            press_ev         = 1'b0;
            release_ev       = 1'b0;
            held_ev          = 1'b0;
            long_press_ev    = 1'b0;
            long_release_ev  = 1'b0;
            multi_press_ev   = 1'b0;
            multi_release_ev = 1'b0;
            click_ev         = '0;
            repeat_ev        = 1'b0;
            total_next       = total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (work_fire) begin
            total_reg <= total_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (work_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (work_fire) begin
            ev_key_reg           <= key_reg;
            ev_press_reg         <= press_ev;
            ev_release_reg       <= release_ev;
            ev_held_reg          <= held_ev;
            ev_long_press_reg    <= long_press_ev;
            ev_long_release_reg  <= long_release_ev;
            ev_multi_press_reg   <= multi_press_ev;
            ev_multi_release_reg <= multi_release_ev;
            ev_click_reg         <= click_ev;
            ev_repeat_reg        <= repeat_ev;
            ev_down_reg          <= total_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_event_key           = ev_key_reg;
    assign m_press_event         = ev_press_reg;
    assign m_release_event       = ev_release_reg;
    assign m_held_event          = ev_held_reg;
    assign m_long_press_event    = ev_long_press_reg;
    assign m_long_release_event  = ev_long_release_reg;
    assign m_multi_press_event   = ev_multi_press_reg;
    assign m_multi_release_event = ev_multi_release_reg;
    assign m_click_count         = ev_click_reg;
    assign m_repeat_event        = ev_repeat_reg;
    assign m_keys_down           = ev_down_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bed_checker.sv =====
// port-level checks of the button event detector and their binding
`timescale 1ns / 1ps
`default_nettype none
module bed_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_press_event,
    input wire logic       m_release_event,
    input wire logic       m_multi_press_event,
    input wire logic       m_multi_release_event,
    input wire logic [7:0] m_click_count,
    input wire logic [4:0] m_keys_down
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_keys_down) &&
                                   $stable(m_click_count)))
        else $error("stalled result changed");

    // with no result waiting the block always takes a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused while result register empty");

    // a multi event carries a click count of at least two
    a_multi_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_multi_press_event || m_multi_release_event)) |->
        (m_click_count >= 8'd2))
        else $error("multi event with click count below two");

    // without a multi event the click count is zero
    a_no_multi_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_multi_press_event && !m_multi_release_event) |->
        (m_click_count == 8'd0))
        else $error("click count without multi event");

    // press and release never come from one sample
    a_press_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_press_event && m_release_event))
        else $error("press and release in one result");

endmodule

bind button_event_detector bed_checker u_bed_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_ready               (s_ready),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_press_event         (m_press_event),
    .m_release_event       (m_release_event),
    .m_multi_press_event   (m_multi_press_event),
    .m_multi_release_event (m_multi_release_event),
    .m_click_count         (m_click_count),
    .m_keys_down           (m_keys_down)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the button event detector
`timescale 1ns / 1ps
module testbench;

    // a sample request and the event word it is expected to produce
    typedef struct packed {
        logic [3:0] key;
        logic       pressed;
        logic       released;
        logic       held;
        logic       long_pr;
        logic       long_rel;
        logic       multi_pr;
        logic       multi_rel;
        logic [7:0] clicks;
        logic       rpt;
        logic [4:0] down;
    } key_event_t;

    // one row of the directed script: a register write or a sample request
    typedef struct packed {
        bit         is_cfg;
        logic [2:0] reg_sel;
        logic [15:0] value;
        logic [3:0] key;
        logic       lvl;
        logic       adv;
        bit         typed;
        key_event_t want;
    } script_row_t;

    typedef enum int {
        SEQ_HOLD,
        SEQ_CLICKS,
        SEQ_NOISE,
        SEQ_IDLE,
        SEQ_DRAIN
    } seq_kind_t;

    // indexes with no register behind them, writes must be ignored
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam logic [15:0] MULTI_FEATURES =
        16'((1 << bed_pkg::FEAT_MULTI_PRESS) | (1 << bed_pkg::FEAT_MULTI_RELEASE));
    localparam logic [3:0] CLICK_KEY = 4'd5;
    localparam int STALL_LIMIT = 2000;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #6 aclk = ~aclk;

    // block inputs, all known from time zero
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;
    logic        s_valid = 1'b0;
    logic [3:0]  s_key_index = 4'd0;
    logic        s_key_level = 1'b0;
    logic        s_tick_advance = 1'b0;
    logic        m_ready = 1'b0;

    // block outputs
    logic        s_ready;
    logic        m_valid;
    logic [3:0]  m_event_key;
    logic        m_press_event;
    logic        m_release_event;
    logic        m_held_event;
    logic        m_long_press_event;
    logic        m_long_release_event;
    logic        m_multi_press_event;
    logic        m_multi_release_event;
    logic [7:0]  m_click_count;
    logic        m_repeat_event;
    logic [4:0]  m_keys_down;

    button_event_detector i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_key_index           (s_key_index),
        .s_key_level           (s_key_level),
        .s_tick_advance        (s_tick_advance),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_event_key           (m_event_key),
        .m_press_event         (m_press_event),
        .m_release_event       (m_release_event),
        .m_held_event          (m_held_event),
        .m_long_press_event    (m_long_press_event),
        .m_long_release_event  (m_long_release_event),
        .m_multi_press_event   (m_multi_press_event),
        .m_multi_release_event (m_multi_release_event),
        .m_click_count         (m_click_count),
        .m_repeat_event        (m_repeat_event),
        .m_keys_down           (m_keys_down)
    );

    // ------------------------------------------------------------------
    // shadow of the detector: tick, key count, per-key debounce and timers
    // ------------------------------------------------------------------
    logic [31:0]     now_tick;
    logic [4:0]      keys_held_cnt;
    logic            key_level_q  [16];
    bed_pkg::phase_t key_phase    [16];
    logic            deb_pending  [16];
    logic [31:0]     deb_due      [16];
    logic [31:0]     long_due     [16];
    logic [31:0]     long_rel_due [16];
    logic            long_done    [16];
    logic [7:0]      press_cnt    [16];
    logic [31:0]     press_due    [16];
    logic [7:0]      rel_cnt      [16];
    logic [31:0]     rel_due      [16];
    logic [31:0]     rpt_due      [16];

    // shadow of the registers
    logic [15:0]                cfg_debounce;
    logic [15:0]                cfg_long;
    logic [15:0]                cfg_multi;
    logic [15:0]                cfg_rpt_first;
    logic [15:0]                cfg_rpt_period;
    logic [bed_pkg::FEAT_W-1:0] cfg_features;

    key_event_t  pending_events [$];
    script_row_t script [$];

    // hand-typed expectation for the next request, set by the driver
    bit         typed_row = 1'b0;
    key_event_t typed_want = '0;

    int mismatches = 0;
    int idle_cycles = 0;
    int gap_pct = 30;
    int stall_pct = 30;
    int rx_stall_left = 0;

    // a deadline counts as reached once the wrapped difference is not negative
    function automatic logic due_now(logic [31:0] deadline);
        logic [31:0] diff;
        diff = now_tick - deadline;
        return !diff[31];
    endfunction

    function automatic logic [31:0] ticks_ahead(logic [15:0] span);
        return now_tick + {16'd0, span};
    endfunction

    // works out the event word of one sample and moves the shadow state on
    function automatic key_event_t detect_key_events(logic [3:0] k, logic lvl, logic adv);
        key_event_t      ev;
        logic            go;
        bed_pkg::phase_t ph;
        ev = '0;
        ev.key = k;
        if (adv) now_tick = now_tick + 32'd1;
        // every 4-bit index names a real key, so no out-of-range path here
        go = (cfg_debounce == 16'd0) || (deb_pending[k] && due_now(deb_due[k]));
        case ({lvl, key_level_q[k]})
            2'b00: begin
                deb_pending[k] = 1'b0;
                key_phase[k] = bed_pkg::PH_NONE;
            end
            2'b01: begin
                if (go) begin
                    key_phase[k] = bed_pkg::PH_RELEASE;
                    ev.released = 1'b1;
                end else if (!deb_pending[k]) begin
                    key_phase[k] = bed_pkg::PH_PRESSING_DEB;
                    deb_due[k] = ticks_ahead(cfg_debounce);
                    deb_pending[k] = 1'b1;
                end
            end
            2'b10: begin
                if (go) begin
                    key_phase[k] = bed_pkg::PH_PRESS;
                    ev.pressed = 1'b1;
                end else if (!deb_pending[k]) begin
                    key_phase[k] = bed_pkg::PH_PRESS_DEB;
                    deb_due[k] = ticks_ahead(cfg_debounce);
                    deb_pending[k] = 1'b1;
                end
            end
            default: begin
                deb_pending[k] = 1'b0;
                key_phase[k] = bed_pkg::PH_PRESSING;
                ev.held = 1'b1;
            end
        endcase
        // a waiting phase is kept; long press and repeat treat a pressing one as pressed
        ph = key_phase[k];
        if (ph != bed_pkg::PH_PRESS_DEB && ph != bed_pkg::PH_PRESSING_DEB)
            key_level_q[k] = lvl;

        if (ph == bed_pkg::PH_PRESS) begin
            if (keys_held_cnt != bed_pkg::TOTAL_MAX) keys_held_cnt = keys_held_cnt + 5'd1;
        end else if (ph == bed_pkg::PH_RELEASE) begin
            if (keys_held_cnt != 5'd0) keys_held_cnt = keys_held_cnt - 5'd1;
        end

        // long press fires once per press, long release on each late release
        if (ph == bed_pkg::PH_PRESS) begin
            long_due[k] = ticks_ahead(cfg_long);
            long_rel_due[k] = ticks_ahead(cfg_long);
            long_done[k] = 1'b0;
        end else if (ph == bed_pkg::PH_PRESSING || ph == bed_pkg::PH_PRESSING_DEB) begin
            if (cfg_features[bed_pkg::FEAT_LONG_PRESS] && due_now(long_due[k]) &&
                !long_done[k]) begin
                long_done[k] = 1'b1;
                ev.long_pr = 1'b1;
            end
        end else if (ph == bed_pkg::PH_RELEASE) begin
            if (cfg_features[bed_pkg::FEAT_LONG_RELEASE] && due_now(long_rel_due[k]))
                ev.long_rel = 1'b1;
        end

        // click counting, saturating, with the window restarted on each click
        if (cfg_features[bed_pkg::FEAT_MULTI_PRESS] && ph == bed_pkg::PH_PRESS) begin
            if (press_cnt[k] != bed_pkg::CLICK_MAX) press_cnt[k] = press_cnt[k] + 8'd1;
            if (press_cnt[k] >= bed_pkg::CLICK_MULTI_MIN) begin
                ev.multi_pr = 1'b1;
                ev.clicks = press_cnt[k];
            end
            press_due[k] = ticks_ahead(cfg_multi);
        end
        if (press_cnt[k] != 8'd0 && due_now(press_due[k])) press_cnt[k] = 8'd0;
        if (cfg_features[bed_pkg::FEAT_MULTI_RELEASE] && ph == bed_pkg::PH_RELEASE) begin
            if (rel_cnt[k] != bed_pkg::CLICK_MAX) rel_cnt[k] = rel_cnt[k] + 8'd1;
            if (rel_cnt[k] >= bed_pkg::CLICK_MULTI_MIN) begin
                ev.multi_rel = 1'b1;
                ev.clicks = rel_cnt[k];
            end
            rel_due[k] = ticks_ahead(cfg_multi);
        end
        if (rel_cnt[k] != 8'd0 && due_now(rel_due[k])) rel_cnt[k] = 8'd0;

        // auto-repeat: first delay after the press, then the period
        if (ph == bed_pkg::PH_PRESS) begin
            rpt_due[k] = ticks_ahead(cfg_rpt_first);
        end else if (ph == bed_pkg::PH_PRESSING || ph == bed_pkg::PH_PRESSING_DEB) begin
            if (cfg_features[bed_pkg::FEAT_REPEAT] && due_now(rpt_due[k])) begin
                ev.rpt = 1'b1;
                rpt_due[k] = ticks_ahead(cfg_rpt_period);
            end
        end

        ev.down = keys_held_cnt;
        return ev;
    endfunction

    function automatic string show_event(key_event_t e);
        return $sformatf({"key=%0d prs=%b rel=%b held=%b lp=%b lr=%b mp=%b mr=%b",
                          " clicks=%0d rpt=%b down=%0d"},
                         e.key, e.pressed, e.released, e.held, e.long_pr, e.long_rel,
                         e.multi_pr, e.multi_rel, e.clicks, e.rpt, e.down);
    endfunction

    // ------------------------------------------------------------------
    // monitor: shadow update on accepted requests, check of accepted results
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        key_event_t got;
        key_event_t want;
        if (!aresetn) begin
            cfg_debounce   = bed_pkg::DEBOUNCE_RST;
            cfg_long       = bed_pkg::LONG_RST;
            cfg_multi      = bed_pkg::MULTI_RST;
            cfg_rpt_first  = bed_pkg::REPEAT_FIRST_RST;
            cfg_rpt_period = bed_pkg::REPEAT_PER_RST;
            cfg_features   = bed_pkg::FEATURES_RST;
            now_tick       = 32'd0;
            keys_held_cnt  = 5'd0;
            for (int i = 0; i < 16; i++) begin
                key_level_q[i]  = 1'b0;
                key_phase[i]    = bed_pkg::PH_NONE;
                deb_pending[i]  = 1'b0;
                deb_due[i]      = 32'd0;
                long_due[i]     = 32'd0;
                long_rel_due[i] = 32'd0;
                long_done[i]    = 1'b0;
                press_cnt[i]    = 8'd0;
                press_due[i]    = 32'd0;
                rel_cnt[i]      = 8'd0;
                rel_due[i]      = 32'd0;
                rpt_due[i]      = 32'd0;
            end
        end else begin
            // register writes land in the shadow at the same edge
            if (cfg_wr_en) begin
                case (cfg_index)
                    bed_pkg::REG_DEBOUNCE:     cfg_debounce   = cfg_data;
                    bed_pkg::REG_LONG:         cfg_long       = cfg_data;
                    bed_pkg::REG_MULTI:        cfg_multi      = cfg_data;
                    bed_pkg::REG_REPEAT_FIRST: cfg_rpt_first  = cfg_data;
                    bed_pkg::REG_REPEAT_PER:   cfg_rpt_period = cfg_data;
                    bed_pkg::REG_FEATURES:     cfg_features   = cfg_data[bed_pkg::FEAT_W-1:0];
                    default: ;
                endcase
            end
            // the shadow always advances, a typed row overrides its answer
            if (s_valid && s_ready) begin
                want = detect_key_events(s_key_index, s_key_level, s_tick_advance);
                pending_events.push_back(typed_row ? typed_want : want);
            end
            if (m_valid && m_ready) begin
                got = {m_event_key, m_press_event, m_release_event, m_held_event,
                       m_long_press_event, m_long_release_event, m_multi_press_event,
                       m_multi_release_event, m_click_count, m_repeat_event, m_keys_down};
                if (pending_events.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result at %0t: %s", $realtime, show_event(got));
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, show_event(want), show_event(got));
                        mismatches++;
                    end
                end
            end
            // watchdog on cycles without any traffic
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(int pct);
        if (pct == 0 || $urandom_range(99) >= pct) return 0;
        if ($urandom_range(7) == 0) return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    // result side back-pressure, driven at the falling edge
    always @(negedge aclk) begin
        int gap;
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            gap = pick_gap(stall_pct);
            if (gap > 0) begin
                m_ready <= 1'b0;
                rx_stall_left = gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver tasks, all called and returning at a falling edge
    // ------------------------------------------------------------------

    // present one sample request, hold it until taken, then maybe pause
    task automatic send_sample(input logic [3:0] k, input logic lvl, input logic adv,
                               input bit typed, input key_event_t want);
        int gap;
        typed_row = typed;
        typed_want = want;
        s_valid <= 1'b1;
        s_key_index <= k;
        s_key_level <= lvl;
        s_tick_advance <= adv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        gap = pick_gap(gap_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_events.size() != 0);
    endtask

    // register writes only with the detector idle
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // script builders
    function automatic void add_sample(logic [3:0] k, logic lvl, logic adv);
        script_row_t row;
        row = '0;
        row.key = k;
        row.lvl = lvl;
        row.adv = adv;
        script.push_back(row);
    endfunction

    function automatic void add_checked(logic [3:0] k, logic lvl, logic adv,
                                        logic prs, logic rel, logic held, logic [4:0] down);
        script_row_t row;
        row = '0;
        row.key = k;
        row.lvl = lvl;
        row.adv = adv;
        row.typed = 1'b1;
        row.want.key = k;
        row.want.pressed = prs;
        row.want.released = rel;
        row.want.held = held;
        row.want.down = down;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [15:0] value);
        script_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_sel = idx;
        row.value = value;
        script.push_back(row);
    endfunction

    function automatic logic [15:0] pick_span();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(6, 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_debounce();
        case ($urandom_range(7))
            0, 1, 2: return 16'd0;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(3, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int        phase;
        int        budget;
        int        sent;
        int        run_len;
        bit        sat_run;
        bit        noisy;
        seq_kind_t kind;
        logic [3:0] key;
        logic [3:0] k;
        logic       lvl;
        logic       adv;
        logic       click_lvl;

        // at reset values: quiet sample, then a press held in debounce
        add_checked(4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0);
        add_checked(4'd15, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0);
        // no debounce, every feature on (upper data bits must be dropped), short timers
        add_cfg(bed_pkg::REG_DEBOUNCE, 16'd0);
        add_cfg(bed_pkg::REG_FEATURES, 16'hFFFF);
        add_cfg(bed_pkg::REG_LONG, 16'd2);
        add_cfg(bed_pkg::REG_MULTI, 16'd4);
        add_cfg(bed_pkg::REG_REPEAT_FIRST, 16'd2);
        add_cfg(bed_pkg::REG_REPEAT_PER, 16'd1);
        add_cfg(REG_SPARE_6, 16'd0);
        add_cfg(REG_SPARE_7, 16'hFFFF);
        // pending debounce passes at once, then hold into long press and repeats
        add_checked(4'd15, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 5'd1);
        add_sample(4'd15, 1'b1, 1'b1);
        add_sample(4'd15, 1'b1, 1'b1);
        add_sample(4'd15, 1'b1, 1'b1);
        // long release, then a second click inside the window
        add_sample(4'd15, 1'b0, 1'b0);
        add_sample(4'd15, 1'b1, 1'b0);
        add_sample(4'd15, 1'b0, 1'b0);
        add_sample(4'd0, 1'b1, 1'b0);
        add_sample(4'd0, 1'b0, 1'b1);
        // longest debounce: the key waits, then a bounce back clears the arm
        add_cfg(bed_pkg::REG_DEBOUNCE, 16'hFFFF);
        add_cfg(bed_pkg::REG_LONG, 16'hFFFF);
        add_cfg(bed_pkg::REG_MULTI, 16'hFFFF);
        add_sample(4'd7, 1'b1, 1'b1);
        add_sample(4'd7, 1'b1, 1'b1);
        add_sample(4'd7, 1'b0, 1'b0);
        // all intervals zero: deadlines reached at once
        add_cfg(bed_pkg::REG_DEBOUNCE, 16'd0);
        add_cfg(bed_pkg::REG_LONG, 16'd0);
        add_cfg(bed_pkg::REG_MULTI, 16'd0);
        add_cfg(bed_pkg::REG_REPEAT_FIRST, 16'd0);
        add_cfg(bed_pkg::REG_REPEAT_PER, 16'd0);
        add_sample(4'd3, 1'b1, 1'b0);
        add_sample(4'd3, 1'b1, 1'b0);
        add_sample(4'd3, 1'b1, 1'b0);
        add_sample(4'd3, 1'b0, 1'b0);
        // arm left set after a transition lets a reversal through at once
        add_cfg(bed_pkg::REG_DEBOUNCE, 16'd2);
        add_sample(4'd9, 1'b1, 1'b0);
        add_sample(4'd9, 1'b1, 1'b1);
        add_sample(4'd9, 1'b1, 1'b1);
        add_sample(4'd9, 1'b0, 1'b0);

        // reset held low from the start, released at a falling edge
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            if (script[i].is_cfg)
                cfg_write(script[i].reg_sel, script[i].value);
            else
                send_sample(script[i].key, script[i].lvl, script[i].adv,
                            script[i].typed, script[i].want);
        end

        // random phases, one of them a long click run to saturate the counts
        click_lvl = 1'b0;
        for (phase = 0; phase < 6; phase++) begin
            sat_run = (phase == 3);
            cfg_write(bed_pkg::REG_DEBOUNCE, sat_run ? 16'd0 : pick_debounce());
            cfg_write(bed_pkg::REG_LONG, pick_span());
            cfg_write(bed_pkg::REG_MULTI, sat_run ? 16'hFFFF : pick_span());
            cfg_write(bed_pkg::REG_REPEAT_FIRST, pick_span());
            cfg_write(bed_pkg::REG_REPEAT_PER, pick_span());
            cfg_write(bed_pkg::REG_FEATURES, (phase == 0) ? 16'hFFFF :
                      (16'($urandom) | (sat_run ? MULTI_FEATURES : 16'd0)));
            if ($urandom_range(1) == 1)
                cfg_write(($urandom_range(1) == 1) ? REG_SPARE_6 : REG_SPARE_7,
                          16'($urandom));
            budget = sat_run ? 560 : 25;
            sent = 0;
            while (sent < budget) begin
                // idling mode per sequence, some stretches with none at all
                gap_pct = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 1) ? 25 : 60);
                stall_pct = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 1) ? 25 : 60);
                if (sat_run) begin
                    kind = SEQ_CLICKS;
                    key = CLICK_KEY;
                    run_len = $urandom_range(60, 20);
                end else begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: kind = SEQ_HOLD;
                        4, 5, 6:    kind = SEQ_CLICKS;
                        7:          kind = SEQ_NOISE;
                        8:          kind = SEQ_IDLE;
                        default:    kind = SEQ_DRAIN;
                    endcase
                    key = 4'($urandom_range(15));
                    run_len = (kind == SEQ_HOLD) ? $urandom_range(20, 6) : $urandom_range(16, 4);
                end
                // sender holds back until every result is in
                if (kind == SEQ_DRAIN) wait_drained();
                for (int j = 0; j < run_len; j++) begin
                    k = key;
                    adv = sat_run ? ($urandom_range(3) == 0) : ($urandom_range(2) != 0);
                    noisy = ($urandom_range(sat_run ? 15 : 7) == 0);
                    if (noisy || kind == SEQ_NOISE || kind == SEQ_DRAIN) begin
                        k = 4'($urandom_range(15));
                        lvl = 1'($urandom_range(1));
                    end else begin
                        case (kind)
                            SEQ_HOLD: lvl = (j + 3 < run_len) ? ($urandom_range(9) != 0) : 1'b0;
                            SEQ_CLICKS: begin
                                // mostly clean toggling, a repeated level now and then
                                lvl = (!sat_run && $urandom_range(4) == 0) ? click_lvl
                                                                           : ~click_lvl;
                                click_lvl = lvl;
                            end
                            default: lvl = 1'b0;
                        endcase
                    end
                    send_sample(k, lvl, adv, 1'b0, '0);
                    sent++;
                end
            end
        end

        // drain, then wait on without traffic to catch any stray result
        wait_drained();
        repeat (4) @(negedge aclk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
